@@ design/quadrature_step_reader_assert.svh @@
// Assertion macros for the quadrature step reader checker.
// Each macro expects clk, and all but QSR_ASSERT_RST also rst_n, to be visible where it is used.
`ifndef QUADRATURE_STEP_READER_ASSERT_SVH
`define QUADRATURE_STEP_READER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define QSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadrature_step_reader: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted
`define QSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadrature_step_reader: next-cycle check failed");

// Next-cycle implication that is checked through reset as well
`define QSR_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("quadrature_step_reader: reset check failed");

`endif

@@ design/qsr_pkg.sv @@
// Shared types, constants and helpers of the quadrature step reader.
// No dependencies; the other design files but the assertion header refer to it by scoped names.
package qsr_pkg;

    // Position counter
    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] CNT_MID = {CNT_BITS{1'b1}} >> 2;

    // Filter run length, saturating
    localparam int RUN_BITS = 5;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    // Step arithmetic widths
    localparam int STEP_BITS = 17;
    localparam int QMAG_BITS = CNT_BITS - 1;
    localparam int GAIN_BITS = 4;
    localparam int PROD_BITS = QMAG_BITS + GAIN_BITS;
    localparam int CMP_BITS  = (PROD_BITS > STEP_BITS + 1) ? PROD_BITS : STEP_BITS + 1;
    localparam int STEP_POS_LIMIT = 65535;
    localparam int STEP_NEG_LIMIT = 65536;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TICK_PERIOD     = 2'd0,
        REG_FILTER_SAMPLES  = 2'd1,
        REG_ACCEL_THRESHOLD = 2'd2,
        REG_ACCEL_GAIN      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0]          tick_period;
        logic [RUN_BITS-1:0]  filter_samples;
        logic [7:0]           accel_threshold;
        logic [GAIN_BITS-1:0] accel_gain;
    } cfg_t;

    // Raw counter read handed from the decoder to the scaler
    typedef struct packed {
        logic                due;
        logic [CNT_BITS-1:0] delta;
    } report_t;

    // Position of an ab pair along the counting-up sequence 00, 10, 11, 01
    function automatic logic [1:0] gray_index(input logic [1:0] ab);
        logic [1:0] idx;
        case (ab)
            2'b00:   idx = 2'd0;
            2'b10:   idx = 2'd1;
            2'b11:   idx = 2'd2;
            2'b01:   idx = 2'd3;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

@@ design/quadrature_step_reader.sv @@
// Top level of the quadrature step reader: x4 decoder with polled reports.
// Depends on qsr_pkg, qsr_config, qsr_decoder and qsr_scaler.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   phase_a, phase_b, poll_tick
//  out      source     out_valid / out_stall step_count, report_due
//  cfg      sink       cfg_write             cfg_index, cfg_data
//
// One sample is taken per cycle while in_stall is low. A sample with poll_tick
// gives one result: the decoder state and the raw counter read are registered
// first, then the scaled step lands in the output register.
// Samples without poll_tick only update the decoder state and give no result.
// in_stall rises only while both the read stage and the output register are
// full and out_stall is high. Reset needs no clearing pass.
module quadrature_step_reader (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               phase_a,
    input  logic                               phase_b,
    input  logic                               poll_tick,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [qsr_pkg::STEP_BITS-1:0] step_count,
    output logic                               report_due,
    input  logic                               cfg_write,
    input  logic [qsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [qsr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    qsr_pkg::cfg_t    cfg;
    logic             recentre;
    logic             accept;
    logic             advance;
    qsr_pkg::report_t rep;
    qsr_pkg::report_t mid_rep_reg;
    logic             mid_valid_reg;
    logic             mid_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic signed [qsr_pkg::STEP_BITS-1:0] step;
    logic signed [qsr_pkg::STEP_BITS-1:0] step_reg;
    logic             due_reg;

    qsr_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .recentre  (recentre)
    );

    qsr_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .phase_a   (phase_a),
        .phase_b   (phase_b),
        .poll_tick (poll_tick),
        .cfg       (cfg),
        .recentre  (recentre),
        .rep       (rep)
    );

    qsr_scaler u_scaler (
        .rep  (mid_rep_reg),
        .cfg  (cfg),
        .step (step)
    );

    // Flow control: the output moves when empty or taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = mid_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        mid_valid_next = in_stall ? mid_valid_reg : (accept && poll_tick);
        out_valid_next = advance ? mid_valid_reg : out_valid_reg;
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the payload stages
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            mid_rep_reg <= rep;
        end
        if (advance && mid_valid_reg)
        begin
            step_reg <= step;
            due_reg  <= mid_rep_reg.due;
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_count = step_reg;
    assign report_due = due_reg;

endmodule

@@ design/qsr_config.sv @@
// Configuration registers of the quadrature step reader.
// Depends on qsr_pkg for the register map and the cfg_t bundle.
module qsr_config (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [qsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [qsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output qsr_pkg::cfg_t                      cfg,
    output logic                               recentre
);

    qsr_pkg::cfg_t cfg_reg;
    qsr_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (qsr_pkg::cfg_reg_t'(cfg_index))
                qsr_pkg::REG_TICK_PERIOD:     cfg_next.tick_period     = cfg_data[15:0];
                qsr_pkg::REG_FILTER_SAMPLES:  cfg_next.filter_samples  =
                    cfg_data[qsr_pkg::RUN_BITS-1:0];
                qsr_pkg::REG_ACCEL_THRESHOLD: cfg_next.accel_threshold = cfg_data[7:0];
                qsr_pkg::REG_ACCEL_GAIN:      cfg_next.accel_gain      =
                    cfg_data[qsr_pkg::GAIN_BITS-1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period     <= 16'd0;
            cfg_reg.filter_samples  <= 5'd8;
            cfg_reg.accel_threshold <= 8'd2;
            cfg_reg.accel_gain      <= 4'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg      = cfg_reg;
    // A period write also re-centres the position counter
    assign recentre = cfg_write &&
                      (qsr_pkg::cfg_reg_t'(cfg_index) == qsr_pkg::REG_TICK_PERIOD);

endmodule

@@ design/qsr_decoder.sv @@
// Phase filter, x4 position counter and poll counter of the step reader.
// Depends on qsr_pkg for widths, the midpoint and the gray index table.
module qsr_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             phase_a,
    input  logic             phase_b,
    input  logic             poll_tick,
    input  qsr_pkg::cfg_t    cfg,
    input  logic             recentre,
    output qsr_pkg::report_t rep
);

    logic [qsr_pkg::CNT_BITS-1:0] position_reg;
    logic [qsr_pkg::CNT_BITS-1:0] position_next;
    logic [15:0]                  poll_count_reg;
    logic [15:0]                  poll_count_next;
    logic [1:0]                   stable_reg;
    logic [1:0]                   stable_next;
    logic [1:0]                   cand_reg;
    logic [1:0]                   cand_next;
    logic [qsr_pkg::RUN_BITS-1:0] run_reg;
    logic [qsr_pkg::RUN_BITS-1:0] run_next;

    logic [1:0]                   ab;
    logic                         take;
    logic [1:0]                   dir;
    logic [qsr_pkg::CNT_BITS-1:0] pos_filtered;
    logic                         due;

    assign ab = {phase_a, phase_b};

    // Advance the filter run or restart it on a new candidate
    always_comb
    begin
        if (ab == cand_reg)
        begin
            cand_next = cand_reg;
            run_next  = (run_reg == qsr_pkg::RUN_MAX) ? run_reg
                                                      : run_reg + qsr_pkg::RUN_BITS'(1);
        end
        else
        begin
            cand_next = ab;
            run_next  = qsr_pkg::RUN_BITS'(1);
        end
    end

    // Count one step per accepted single-phase change
    always_comb
    begin
        take         = (run_next >= cfg.filter_samples) && (cand_next != stable_reg);
        dir          = qsr_pkg::gray_index(cand_next) - qsr_pkg::gray_index(stable_reg);
        pos_filtered = position_reg;
        stable_next  = stable_reg;
        if (take)
        begin
            stable_next = cand_next;
            if (dir == 2'd1)
            begin
                pos_filtered = position_reg + qsr_pkg::CNT_BITS'(1);
            end
            else if (dir == 2'd3)
            begin
                pos_filtered = position_reg - qsr_pkg::CNT_BITS'(1);
            end
        end
    end

    // Handle the poll tick after counting
    always_comb
    begin
        due             = poll_tick && (poll_count_reg >= cfg.tick_period);
        poll_count_next = poll_count_reg;
        if (poll_tick)
        begin
            poll_count_next = due ? 16'd0 : poll_count_reg + 16'd1;
        end
        position_next = due ? qsr_pkg::CNT_MID : pos_filtered;
    end

    // Hold the decoder state; update it on each transfer, re-centre on a period write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= qsr_pkg::CNT_MID;
            poll_count_reg <= 16'd0;
            stable_reg     <= 2'b11;
            cand_reg       <= 2'b11;
            run_reg        <= '0;
        end
        else if (accept)
        begin
            position_reg   <= recentre ? qsr_pkg::CNT_MID : position_next;
            poll_count_reg <= poll_count_next;
            stable_reg     <= stable_next;
            cand_reg       <= cand_next;
            run_reg        <= run_next;
        end
        else if (recentre)
        begin
            position_reg <= qsr_pkg::CNT_MID;
        end
    end

    assign rep.due   = due;
    assign rep.delta = pos_filtered - qsr_pkg::CNT_MID;

endmodule

@@ design/qsr_scaler.sv @@
// Step scaling of the step reader: divide by four with rounding, apply the
// acceleration gain and saturate. Depends on qsr_pkg for widths and limits.
module qsr_scaler (
    input  qsr_pkg::report_t                    rep,
    input  qsr_pkg::cfg_t                       cfg,
    output logic signed [qsr_pkg::STEP_BITS-1:0] step
);

    logic                          neg;
    logic [qsr_pkg::CNT_BITS-1:0]  mag;
    logic [qsr_pkg::CNT_BITS:0]    rsum;
    logic [qsr_pkg::QMAG_BITS-1:0] qmag;
    logic                          big;
    logic [qsr_pkg::PROD_BITS-1:0] prod;
    logic [qsr_pkg::CMP_BITS-1:0]  wide;
    logic [qsr_pkg::CMP_BITS-1:0]  limit;
    logic [qsr_pkg::STEP_BITS-1:0] smag;

    // Magnitude of the delta, then round half away from zero
    always_comb
    begin
        neg  = rep.delta[qsr_pkg::CNT_BITS-1];
        mag  = neg ? (~rep.delta + qsr_pkg::CNT_BITS'(1)) : rep.delta;
        rsum = {1'b0, mag} + (qsr_pkg::CNT_BITS + 1)'(2);
        qmag = rsum[qsr_pkg::CNT_BITS:2];
    end

    // Apply the gain to large steps and clamp to the output range
    always_comb
    begin
        big   = qsr_pkg::CMP_BITS'(qmag) > qsr_pkg::CMP_BITS'(cfg.accel_threshold);
        prod  = big ? qsr_pkg::PROD_BITS'(qmag) * qsr_pkg::PROD_BITS'(cfg.accel_gain)
                    : qsr_pkg::PROD_BITS'(qmag);
        wide  = qsr_pkg::CMP_BITS'(prod);
        limit = neg ? qsr_pkg::CMP_BITS'(qsr_pkg::STEP_NEG_LIMIT)
                    : qsr_pkg::CMP_BITS'(qsr_pkg::STEP_POS_LIMIT);
        smag  = (wide > limit) ? qsr_pkg::STEP_BITS'(limit) : qsr_pkg::STEP_BITS'(wide);
        if (!rep.due)
        begin
            step = '0;
        end
        else if (neg)
        begin
            step = signed'(~smag + qsr_pkg::STEP_BITS'(1));
        end
        else
        begin
            step = signed'(smag);
        end
    end

endmodule

@@ design/qsr_checker.sv @@
// Port-level checker for the quadrature step reader, bound to the top level.
// Depends on quadrature_step_reader_assert.svh for the assertion macros.
`include "quadrature_step_reader_assert.svh"

module qsr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [qsr_pkg::STEP_BITS-1:0] step_count,
    input logic                               report_due
);

    // Hold a stalled result
    `QSR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(step_count) && $stable(report_due))

    // A report that is not due carries no step
    `QSR_ASSERT_IMP(a_zero_not_due, out_valid && !report_due, step_count == '0)

    // Stall the input only behind a blocked output
    `QSR_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // Drop every result while in reset
    `QSR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind quadrature_step_reader qsr_checker u_qsr_checker (.*);
